FILE: src/bad_pkg.sv
package bad_pkg;

  // Defaults for the top level parameters
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_BLOCK_DEF  = 16;
  localparam int PIXEL_BITS_DEF = 16;

  // Register field widths and result width
  localparam int IMG_W_BITS    = 13;
  localparam int BLK_REG_BITS  = 5;
  localparam int AVG_BITS      = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = IMG_W_BITS;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register reset values
  localparam logic [IMG_W_BITS-1:0]   IMG_W_RST = 13'd640;
  localparam logic [BLK_REG_BITS-1:0] BLK_W_RST = 5'd2;
  localparam logic [BLK_REG_BITS-1:0] BLK_H_RST = 5'd2;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_HEIGHT = 2'd2;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } bad_back_state_t;

endpackage

FILE: src/bad_if.sv
// Pixel input channel
interface bad_in_if #(
  parameter int PIXEL_BITS = bad_pkg::PIXEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;
  logic                  frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

// Block average output channel
interface bad_out_if;
  logic                          valid;
  logic                          ready;
  logic [bad_pkg::AVG_BITS-1:0]  average;
  logic                          row_end;

  modport source (output valid, average, row_end, input ready);
  modport sink   (input valid, average, row_end, output ready);
endinterface

// Register write channel
interface bad_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bad_pkg::CFG_IDX_BITS-1:0]  index;
  logic [bad_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/box_average_downsampler.sv
// Channel  Dir  Payload                       Transaction
// in_ch    in   pixel, frame_start            valid & ready
// out_ch   out  average, row_end              valid & ready
// cfg_ch   in   index, data                   valid & ready
//
// Pixels are taken one per cycle unless the front stalls, which it does when
// the queue to the divider is full. The back divider works on one block
// average at a time, from queue pop until the result is loaded for output.
// Averages come only on the last row of a band, one per block_width pixels,
// so there the input stalls once the queue fills if the back falls behind.
// After each register write the input stalls while the blocks-per-row
// count is recomputed.
// Reset is synchronous; the line store needs no clearing after reset.
module box_average_downsampler #(
  parameter int MAX_WIDTH  = bad_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BLOCK  = bad_pkg::MAX_BLOCK_DEF,
  parameter int PIXEL_BITS = bad_pkg::PIXEL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bad_in_if.sink    in_ch,
  bad_out_if.source out_ch,
  bad_cfg_if.sink   cfg_ch
);

  localparam int ENTRY_W = PIXEL_BITS + 2 * $clog2(MAX_BLOCK)
                           + 2 * $clog2(MAX_BLOCK + 1) + 1;

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;

  // Position tracking and line store
  bad_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_BLOCK  (MAX_BLOCK),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  // Block sums waiting for division
  bad_fifo #(
    .DATA_W (ENTRY_W),
    .DEPTH  (bad_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Division and output register
  bad_back #(
    .MAX_BLOCK  (MAX_BLOCK),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTH
  // Back only takes an entry that exists
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // One division at a time: no pop in the cycle after a pop
  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("back took two entries back to back");

  // Input holds off while blocks per row is recomputed
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_ch.valid && cfg_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after a register write");
`endif

endmodule

FILE: src/bad_div.sv
// Restoring divider, one quotient bit per cycle
module bad_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: src/bad_fifo.sv
// Small queue between front and back, fall-through read
module bad_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = bad_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return q;
  endfunction

  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = slot_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: src/bad_front.sv
// Front: takes pixels, tracks position, accumulates block sums through
// the line store and queues finished block sums for division.
module bad_front #(
  parameter int MAX_WIDTH  = bad_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BLOCK  = bad_pkg::MAX_BLOCK_DEF,
  parameter int PIXEL_BITS = bad_pkg::PIXEL_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  bad_in_if.sink         in_ch,
  bad_cfg_if.sink        cfg_ch,
  output logic           q_push,
  output logic [PIXEL_BITS+2*$clog2(MAX_BLOCK)+2*$clog2(MAX_BLOCK+1):0] q_data,
  input  logic           q_full
);

  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int IDX_W  = $clog2(MAX_WIDTH);
  localparam int BLK_W  = $clog2(MAX_BLOCK + 1);
  localparam int CB_W   = $clog2(MAX_BLOCK);
  localparam int HS_W   = PIXEL_BITS + CB_W;
  localparam int SUM_W  = PIXEL_BITS + 2 * CB_W;
  localparam int AREA_W = 2 * BLK_W;

  localparam int W_RST_C    = (int'(bad_pkg::IMG_W_RST) > MAX_WIDTH) ? MAX_WIDTH
                                : int'(bad_pkg::IMG_W_RST);
  localparam int BW_RST_C   = (int'(bad_pkg::BLK_W_RST) > MAX_BLOCK) ? MAX_BLOCK
                                : int'(bad_pkg::BLK_W_RST);
  localparam int BLOCKS_RST = W_RST_C / BW_RST_C;

  // Registers
  logic [bad_pkg::IMG_W_BITS-1:0]   img_w_r;
  logic [bad_pkg::BLK_REG_BITS-1:0] blk_w_r;
  logic [bad_pkg::BLK_REG_BITS-1:0] blk_h_r;
  logic [W_W-1:0]                   blocks_r;
  logic                             recalc_r;

  // Position state
  logic [IDX_W-1:0] cc_r,  cc_nxt;
  logic [CB_W-1:0]  cib_r, cib_nxt;
  logic [CB_W-1:0]  rib_r, rib_nxt;
  logic [W_W-1:0]   bc_r,  bc_nxt;
  logic [HS_W-1:0]  hs_r,  hs_nxt;

  // Line store stage
  logic [SUM_W-1:0] band_mem_r [MAX_WIDTH];
  logic [SUM_W-1:0] rd_data_r;
  logic             b_valid_r;
  logic [HS_W-1:0]  b_band_r;
  logic             b_use_mem_r;
  logic             b_emit_r;
  logic             b_row_end_r;
  logic [IDX_W-1:0] b_addr_r;

  logic             cfg_acc;
  logic             in_acc;
  logic [W_W-1:0]   w_c;
  logic [BLK_W-1:0] bw_c;
  logic [BLK_W-1:0] bh_c;
  logic [AREA_W-1:0] area_c;
  logic             div_busy;
  logic             div_done;
  logic [W_W-1:0]   div_quo;

  logic [IDX_W-1:0] cc_e;
  logic [CB_W-1:0]  cib_e;
  logic [CB_W-1:0]  rib_e;
  logic [W_W-1:0]   bc_e;
  logic [HS_W-1:0]  hs_e;
  logic [HS_W-1:0]  hs_add;
  logic             active;
  logic             last_col;
  logic             blk_done;
  logic             row_last;
  logic             band_last;
  logic [IDX_W-1:0] rd_addr;

  logic [SUM_W-1:0] band_sum;
  logic             b_done;
  logic             mem_we;

  // Register values brought into range
  always_comb begin
    if (img_w_r == '0) w_c = W_W'(1);
    else if (int'(img_w_r) > MAX_WIDTH) w_c = W_W'(MAX_WIDTH);
    else w_c = W_W'(img_w_r);

    if (blk_w_r == '0) bw_c = BLK_W'(1);
    else if (int'(blk_w_r) > MAX_BLOCK) bw_c = BLK_W'(MAX_BLOCK);
    else bw_c = BLK_W'(blk_w_r);

    if (blk_h_r == '0) bh_c = BLK_W'(1);
    else if (int'(blk_h_r) > MAX_BLOCK) bh_c = BLK_W'(MAX_BLOCK);
    else bh_c = BLK_W'(blk_h_r);
  end

  assign area_c = AREA_W'(bw_c) * AREA_W'(bh_c);

  // Register writes
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= bad_pkg::IMG_W_RST;
      blk_w_r  <= bad_pkg::BLK_W_RST;
      blk_h_r  <= bad_pkg::BLK_H_RST;
      recalc_r <= 1'b0;
      blocks_r <= W_W'(BLOCKS_RST);
    end else begin
      recalc_r <= cfg_acc;
      if (cfg_acc) begin
        unique case (cfg_ch.index)
          bad_pkg::REG_IMAGE_WIDTH:  img_w_r <= cfg_ch.data[bad_pkg::IMG_W_BITS-1:0];
          bad_pkg::REG_BLOCK_WIDTH:  blk_w_r <= cfg_ch.data[bad_pkg::BLK_REG_BITS-1:0];
          bad_pkg::REG_BLOCK_HEIGHT: blk_h_r <= cfg_ch.data[bad_pkg::BLK_REG_BITS-1:0];
          default: ;
        endcase
      end
      if (div_done) blocks_r <= div_quo;
    end
  end

  // Full blocks per row, recomputed after each register write
  bad_div #(
    .NUM_W (W_W),
    .DEN_W (BLK_W)
  ) u_blocks_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (recalc_r),
    .num   (w_c),
    .den   (bw_c),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Line store stage: add stored partial sum, then store or queue
  assign band_sum = SUM_W'(b_band_r) + (b_use_mem_r ? rd_data_r : '0);
  assign b_done   = !b_emit_r || !q_full;
  assign mem_we   = b_valid_r && !b_emit_r;
  assign q_push   = b_valid_r && b_emit_r && !q_full;
  assign q_data   = {band_sum, area_c, b_row_end_r};

  // Held off until the new blocks-per-row count has landed in blocks_r, and while the stage cannot pass its sum on
  assign in_ch.ready = !recalc_r && !div_busy && !div_done && (!b_valid_r || b_done);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Position as seen by this pixel, frame start clears it first
  always_comb begin
    if (in_ch.frame_start) begin
      cc_e  = '0;
      cib_e = '0;
      rib_e = '0;
      bc_e  = '0;
      hs_e  = '0;
    end else begin
      cc_e  = cc_r;
      cib_e = cib_r;
      rib_e = rib_r;
      bc_e  = bc_r;
      hs_e  = hs_r;
    end
  end

  assign hs_add    = hs_e + HS_W'(in_ch.pixel);
  assign active    = bc_e < blocks_r;
  assign last_col  = (BLK_W'(cib_e) + BLK_W'(1)) >= bw_c;
  assign blk_done  = active && last_col;
  assign row_last  = (W_W'(cc_e) + W_W'(1)) >= w_c;
  assign band_last = (BLK_W'(rib_e) + BLK_W'(1)) >= bh_c;
  assign rd_addr   = bc_e[IDX_W-1:0];

  // Next position
  always_comb begin
    cc_nxt  = cc_e;
    cib_nxt = cib_e;
    rib_nxt = rib_e;
    bc_nxt  = bc_e;
    hs_nxt  = hs_e;
    if (active) begin
      if (last_col) begin
        hs_nxt  = '0;
        cib_nxt = '0;
        bc_nxt  = bc_e + W_W'(1);
      end else begin
        hs_nxt  = hs_add;
        cib_nxt = cib_e + CB_W'(1);
      end
    end
    if (row_last) begin
      cc_nxt  = '0;
      cib_nxt = '0;
      bc_nxt  = '0;
      hs_nxt  = '0;
      rib_nxt = band_last ? '0 : rib_e + CB_W'(1);
    end else begin
      cc_nxt = cc_e + IDX_W'(1);
    end
  end

  // Position and stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r      <= '0;
      cib_r     <= '0;
      rib_r     <= '0;
      bc_r      <= '0;
      hs_r      <= '0;
      b_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cc_r      <= cc_nxt;
        cib_r     <= cib_nxt;
        rib_r     <= rib_nxt;
        bc_r      <= bc_nxt;
        hs_r      <= hs_nxt;
        b_valid_r <= blk_done;
      end else if (b_done) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_band_r    <= hs_add;
      b_use_mem_r <= rib_e != '0;
      b_emit_r    <= band_last;
      b_row_end_r <= (bc_e + W_W'(1)) >= blocks_r;
      b_addr_r    <= rd_addr;
    end
  end

  // Line store, with the write of this cycle forwarded to the read
  always_ff @(posedge clk) begin
    if (mem_we) band_mem_r[b_addr_r] <= band_sum;
    if (in_acc) begin
      if (mem_we && (b_addr_r == rd_addr)) rd_data_r <= band_sum;
      else rd_data_r <= band_mem_r[rd_addr];
    end
  end

endmodule

FILE: src/bad_back.sv
// Back: divides each queued block sum by the block area
module bad_back #(
  parameter int MAX_BLOCK  = bad_pkg::MAX_BLOCK_DEF,
  parameter int PIXEL_BITS = bad_pkg::PIXEL_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  logic [PIXEL_BITS+2*$clog2(MAX_BLOCK)+2*$clog2(MAX_BLOCK+1):0] q_data,
  output logic           q_pop,
  bad_out_if.source      out_ch
);

  localparam int BLK_W   = $clog2(MAX_BLOCK + 1);
  localparam int CB_W    = $clog2(MAX_BLOCK);
  localparam int SUM_W   = PIXEL_BITS + 2 * CB_W;
  localparam int AREA_W  = 2 * BLK_W;
  localparam int ENTRY_W = SUM_W + AREA_W + 1;
  localparam int QW      = (SUM_W > bad_pkg::AVG_BITS) ? SUM_W : bad_pkg::AVG_BITS;

  bad_pkg::bad_back_state_t state_r, state_nxt;

  logic                         out_valid_r;
  logic [bad_pkg::AVG_BITS-1:0] avg_r;
  logic                         out_row_end_r;
  logic                         row_end_r;
  logic                         out_free;
  logic                         load_out;
  logic                         div_busy;
  logic                         div_done;
  logic [QW-1:0]                div_quo;

  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bad_pkg::BK_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      bad_pkg::BK_IDLE: begin
        if (!q_empty && !div_busy) begin
          q_pop     = 1'b1;
          state_nxt = bad_pkg::BK_DIV;
        end
      end
      bad_pkg::BK_DIV: begin
        if (div_done) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = bad_pkg::BK_IDLE;
          end else begin
            state_nxt = bad_pkg::BK_HOLD;
          end
        end
      end
      bad_pkg::BK_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = bad_pkg::BK_IDLE;
        end
      end
      default: state_nxt = bad_pkg::BK_IDLE;
    endcase
  end

  bad_div #(
    .NUM_W (QW),
    .DEN_W (AREA_W)
  ) u_avg_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (q_pop),
    .num   (QW'(q_data[ENTRY_W-1 -: SUM_W])),
    .den   (q_data[AREA_W:1]),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Row flag travels beside the division
  always_ff @(posedge clk) begin
    if (q_pop) row_end_r <= q_data[0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      avg_r         <= div_quo[bad_pkg::AVG_BITS-1:0];
      out_row_end_r <= row_end_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.average = avg_r;
  assign out_ch.row_end = out_row_end_r;

endmodule
